@@ src/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, codes and the reverse alphabet lookup for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] PadChar = 8'h3d;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StInvalid  = 2'd1,
    StPadLen   = 2'd2,
    StShortLen = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_valid;
    logic       message_end;
    status_e    status;
  } out_item_t;

  // classified character, handed from front to back
  typedef struct packed {
    logic [5:0] value;
    logic       is_pad;
    logic       no_value;
    logic       last;
  } class_t;

  // returns {no_value, value[5:0]}
  function automatic logic [6:0] lookup6(input logic [7:0] c, input logic url);
    logic [7:0] d;
    logic [6:0] r;
    d = 8'd0;
    r = 7'h40;
    if (c >= 8'h41 && c <= 8'h5a) begin
      d = c - 8'h41;
      r = {1'b0, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      d = c - 8'h61 + 8'd26;
      r = {1'b0, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
      r = {1'b0, d[5:0]};
    end else if (c == 8'h2b) begin
      r = 7'd62;
    end else if (c == 8'h2f) begin
      r = 7'd63;
    end else if (url && c == 8'h2d) begin
      r = 7'd62;
    end else if (url && c == 8'h5f) begin
      r = 7'd63;
    end
    return r;
  endfunction

endpackage

@@ src/b64d_fifo.sv @@
// ----------------------------------------------------------------------------
// b64d_fifo
// Small register queue with count-based full and empty flags.
// ----------------------------------------------------------------------------
module b64d_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push_ok, pop_ok;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_d = count_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ src/b64d_front.sv @@
// ----------------------------------------------------------------------------
// b64d_front
// Classifies each incoming character through the reverse alphabet.
// ----------------------------------------------------------------------------
module b64d_front (
  input  b64d_pkg::in_item_t item_i,
  input  logic               url_alphabet_i,
  output b64d_pkg::class_t   class_o
);

  logic [6:0] lut;

  assign lut = b64d_pkg::lookup6(item_i.char_code, url_alphabet_i);

  always_comb begin
    class_o.value    = lut[5:0];
    class_o.no_value = lut[6];
    class_o.is_pad   = (item_i.char_code == b64d_pkg::PadChar);
    class_o.last     = item_i.last;
  end

endmodule

@@ src/b64d_back.sv @@
// ----------------------------------------------------------------------------
// b64d_back
// Quartet state machine: gathers 6-bit groups, emits bytes and final status.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64d_pkg::class_t    class_i,
  input  logic                class_valid_i,
  output logic                class_pop_o,
  output b64d_pkg::out_item_t out_o,
  output logic                out_push_o,
  input  logic                out_full_i
);

  logic [17:0] group_q, group_d;
  logic [1:0]  slot_q, slot_d;
  logic [1:0]  pad_q, pad_d;
  logic        err_q, err_d;

  logic [1:0]  next_slot;
  logic [17:0] acc;
  logic        have_byte;
  logic [7:0]  byte_val;
  b64d_pkg::status_e status;

  assign class_pop_o = class_valid_i && !out_full_i;
  assign next_slot   = slot_q + 2'd1;
  assign acc         = (slot_q == 2'd0) ? {12'd0, class_i.value}
                                        : {group_q[11:0], class_i.value};

  always_comb begin
    group_d   = group_q;
    pad_d     = pad_q;
    err_d     = err_q;
    have_byte = 1'b0;
    byte_val  = 8'd0;
    if (class_i.is_pad) begin
      // pad in the first half of a quartet is illegal
      if (!slot_q[1]) begin
        err_d = 1'b1;
      end
      if (pad_q != 2'd3) begin
        pad_d = pad_q + 2'd1;
      end
    end else if (class_i.no_value || pad_q != 2'd0) begin
      err_d = 1'b1;
    end else begin
      group_d = acc;
      unique case (slot_q)
        2'd1:    begin byte_val = acc[11:4]; have_byte = 1'b1; end
        2'd2:    begin byte_val = acc[9:2];  have_byte = 1'b1; end
        2'd3:    begin byte_val = acc[7:0];  have_byte = 1'b1; end
        default: begin byte_val = 8'd0;      have_byte = 1'b0; end
      endcase
    end
    if (err_d) begin
      have_byte = 1'b0;
    end

    status = b64d_pkg::StOk;
    if (class_i.last) begin
      priority if (class_i.is_pad && next_slot != 2'd0) begin
        status = b64d_pkg::StPadLen;
      end else if (!class_i.is_pad && next_slot == 2'd1) begin
        status = b64d_pkg::StShortLen;
      end else if (err_d) begin
        status = b64d_pkg::StInvalid;
      end else begin
        status = b64d_pkg::StOk;
      end
      if (status != b64d_pkg::StOk) begin
        have_byte = 1'b0;
      end
    end

    slot_d = next_slot;
    if (class_i.last) begin
      group_d = '0;
      slot_d  = '0;
      pad_d   = '0;
      err_d   = 1'b0;
    end
  end

  assign out_push_o        = class_pop_o && (class_i.last || have_byte);
  assign out_o.byte_value  = have_byte ? byte_val : 8'd0;
  assign out_o.byte_valid  = have_byte;
  assign out_o.message_end = class_i.last;
  assign out_o.status      = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
      slot_q  <= '0;
      pad_q   <= '0;
      err_q   <= 1'b0;
    end else if (class_pop_o) begin
      group_q <= group_d;
      slot_q  <= slot_d;
      pad_q   <= pad_d;
      err_q   <= err_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_push_needs_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> class_pop_o)
    else $error("result pushed without consuming an item");

  a_mid_item_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push_o && !out_o.message_end) |-> (out_o.byte_valid && !err_q))
    else $error("mid-message result without byte");

  a_status_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push_o && out_o.status != b64d_pkg::StOk) |-> out_o.message_end)
    else $error("error status before message end");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (class_pop_o && class_i.last) |=> (slot_q == 2'd0 && pad_q == 2'd0 && !err_q))
    else $error("message state not cleared after last item");
`endif

endmodule

@@ src/base64_stream_decoder_core.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming base64 decoder, one character per item, standard or URL alphabet.
// ----------------------------------------------------------------------------
//  channel | ports                      | handshake
//  --------+----------------------------+------------------------------------
//  input   | in_item_i, push, full      | accepted when push && !full
//  result  | out_item_o, pop, empty     | accepted when pop && !empty
//  config  | cfg_we_i, cfg_wdata_i      | url_alphabet written when cfg_we_i
//
//  One item per cycle sustained unless the result queue is held full. The
//  front lookup writes a queue, the quartet logic writes the result queue.
//  Reset clears the queues, quartet state and the alphabet select; no sweep.
//  full depends only on the input queue fill, never on pop.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core #(
  parameter int unsigned MidDepth = 2,
  parameter int unsigned OutDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64d_pkg::in_item_t  in_item_i,
  input  logic                push,
  output logic                full,
  output b64d_pkg::out_item_t out_item_o,
  output logic                empty,
  input  logic                pop,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);

  localparam int unsigned ClassW = $bits(b64d_pkg::class_t);
  localparam int unsigned OutW   = $bits(b64d_pkg::out_item_t);

  logic                url_q;
  b64d_pkg::class_t    front_class, mid_class;
  logic [ClassW-1:0]   mid_data;
  logic                mid_empty, mid_pop;
  b64d_pkg::out_item_t back_out;
  logic                out_push, out_full;
  logic [OutW-1:0]     out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_q <= 1'b0;
    end else if (cfg_we_i) begin
      url_q <= cfg_wdata_i;
    end
  end

  b64d_front u_front (
    .item_i         (in_item_i),
    .url_alphabet_i (url_q),
    .class_o        (front_class)
  );

  b64d_fifo #(
    .Width (ClassW),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_class),
    .full_o  (full),
    .pop_i   (mid_pop),
    .data_o  (mid_data),
    .empty_o (mid_empty)
  );

  assign mid_class = b64d_pkg::class_t'(mid_data);

  b64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .class_i       (mid_class),
    .class_valid_i (!mid_empty),
    .class_pop_o   (mid_pop),
    .out_o         (back_out),
    .out_push_o    (out_push),
    .out_full_i    (out_full)
  );

  b64d_fifo #(
    .Width (OutW),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (back_out),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data),
    .empty_o (empty)
  );

  assign out_item_o = b64d_pkg::out_item_t'(out_data);

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for base64_stream_decoder_core: directed messages, then
// random well-formed, broken and noise messages under both alphabet settings,
// with random idling on both queue sides and a scoreboard that predicts every
// decoded byte and final status.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemsPerPhase = 175;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned CycleLimit    = 300000;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned HoldCycles    = 300;

  // predicts the decoder and holds the results still to come
  class byte_scoreboard;
    logic                  url;
    logic [17:0]           grp;
    logic [1:0]            slot;
    logic [1:0]            pads;
    logic                  err;
    b64d_pkg::out_item_t   expected_bytes[$];
    int unsigned           errors;
    int unsigned           checked;

    function new();
      url     = 1'b0;
      grp     = '0;
      slot    = '0;
      pads    = '0;
      err     = 1'b0;
      errors  = 0;
      checked = 0;
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    // {invalid, value}
    function logic [6:0] char_value(logic [7:0] c);
      logic [6:0] v;
      v = 7'h40;
      if (c >= "A" && c <= "Z") begin
        v = {1'b0, 6'(c - "A")};
      end else if (c >= "a" && c <= "z") begin
        v = {1'b0, 6'(c - "a" + 8'd26)};
      end else if (c >= "0" && c <= "9") begin
        v = {1'b0, 6'(c - "0" + 8'd52)};
      end else if (c == "+" || (url && c == "-")) begin
        v = 7'd62;
      end else if (c == "/" || (url && c == "_")) begin
        v = 7'd63;
      end
      return v;
    endfunction

    function void note_char(b64d_pkg::in_item_t it);
      logic [6:0]          look;
      logic [1:0]          nslot;
      logic [23:0]         acc;
      logic [7:0]          b;
      logic                have;
      logic                pad;
      b64d_pkg::status_e   st;
      b64d_pkg::out_item_t r;
      pad   = (it.char_code == b64d_pkg::PadChar);
      nslot = slot + 2'd1;
      have  = 1'b0;
      b     = '0;
      if (pad) begin
        if (slot < 2'd2) err = 1'b1;
        if (pads != 2'd3) pads = pads + 2'd1;
      end else begin
        look = char_value(it.char_code);
        if (look[6] || pads != 2'd0) begin
          err = 1'b1;
        end else begin
          acc = (slot == 2'd0) ? {18'd0, look[5:0]} : {grp, look[5:0]};
          case (slot)
            2'd1: begin
              b = acc[11:4];
              have = 1'b1;
            end
            2'd2: begin
              b = acc[9:2];
              have = 1'b1;
            end
            2'd3: begin
              b = acc[7:0];
              have = 1'b1;
            end
            default: ;
          endcase
          grp = acc[17:0];
        end
      end
      slot = nslot;
      if (err) have = 1'b0;
      if (it.last) begin
        // length errors win over an invalid character
        if (pad && nslot != 2'd0)        st = b64d_pkg::StPadLen;
        else if (!pad && nslot == 2'd1)  st = b64d_pkg::StShortLen;
        else if (err)                    st = b64d_pkg::StInvalid;
        else                             st = b64d_pkg::StOk;
        if (st != b64d_pkg::StOk) have = 1'b0;
        r.byte_value  = have ? b : 8'd0;
        r.byte_valid  = have;
        r.message_end = 1'b1;
        r.status      = st;
        expected_bytes.push_back(r);
        grp  = '0;
        slot = '0;
        pads = '0;
        err  = 1'b0;
      end else if (have) begin
        r.byte_value  = b;
        r.byte_valid  = 1'b1;
        r.message_end = 1'b0;
        r.status      = b64d_pkg::StOk;
        expected_bytes.push_back(r);
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_byte(b64d_pkg::out_item_t got);
      b64d_pkg::out_item_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = expected_bytes.pop_front();
      checked++;
      if (got.byte_value !== want.byte_value)
        report($sformatf("byte_value %h, want %h", got.byte_value, want.byte_value));
      if (got.byte_valid !== want.byte_valid)
        report($sformatf("byte_valid %b, want %b", got.byte_valid, want.byte_valid));
      if (got.message_end !== want.message_end)
        report($sformatf("message_end %b, want %b", got.message_end, want.message_end));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  b64d_pkg::in_item_t  in_item;
  logic                push;
  logic                full;
  b64d_pkg::out_item_t out_item;
  logic                empty;
  logic                pop;
  logic                cfg_we;
  logic                cfg_wdata;

  byte_scoreboard board;
  int unsigned    cycles;
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  int unsigned    hold_left;
  int unsigned    chars_sent;
  int unsigned    msgs_sent;
  int unsigned    phase_items;
  logic [7:0]     msg_q[$];

  base64_stream_decoder_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item),
    .push       (push),
    .full       (full),
    .out_item_o (out_item),
    .empty      (empty),
    .pop        (pop),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // sample both handshakes before this edge's updates land
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) board.note_char(in_item);
      if (pop && !empty) board.check_byte(out_item);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task send_item(b64d_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task send_message();
    b64d_pkg::in_item_t it;
    for (int i = 0; i < msg_q.size(); i++) begin
      it.char_code = msg_q[i];
      it.last      = (i == msg_q.size() - 1);
      send_item(it);
      chars_sent++;
      phase_items++;
    end
    msgs_sent++;
  endtask

  task send_text(string s);
    msg_q.delete();
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
    send_message();
  endtask

  task drain();
    push <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task write_alphabet(logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    board.url = v;
  endtask

  function logic [7:0] enc_char(logic [5:0] v, logic url_form);
    if (v < 6'd26) return 8'("A") + v;
    if (v < 6'd52) return 8'("a") + v - 8'd26;
    if (v < 6'd62) return 8'("0") + v - 8'd52;
    if (v == 6'd62) return url_form ? 8'("-") : 8'("+");
    return url_form ? 8'("_") : 8'("/");
  endfunction

  // leftover low bits stay random on purpose
  task build_encoded(int unsigned nbytes, logic padded, logic url_mix);
    logic [7:0] b0, b1, b2;
    int unsigned rem;
    msg_q.delete();
    for (int unsigned i = 0; i < nbytes; i += 3) begin
      b0  = 8'($urandom);
      b1  = 8'($urandom);
      b2  = 8'($urandom);
      rem = (nbytes - i > 3) ? 3 : nbytes - i;
      msg_q.push_back(enc_char(b0[7:2], url_mix & 1'($urandom_range(1))));
      msg_q.push_back(enc_char({b0[1:0], b1[7:4]}, url_mix & 1'($urandom_range(1))));
      if (rem >= 2)
        msg_q.push_back(enc_char({b1[3:0], b2[7:6]}, url_mix & 1'($urandom_range(1))));
      else if (padded) msg_q.push_back(b64d_pkg::PadChar);
      if (rem == 3) msg_q.push_back(enc_char(b2[5:0], url_mix & 1'($urandom_range(1))));
      else if (padded) msg_q.push_back(b64d_pkg::PadChar);
    end
  endtask

  task random_message(logic url);
    int unsigned kind;
    int unsigned n;
    int unsigned pos;
    kind = $urandom_range(99);
    n = ($urandom_range(19) == 0) ? $urandom_range(12, 8) : $urandom_range(7, 1);
    if (kind < 70) begin
      build_encoded(n, 1'($urandom_range(1)), url | ($urandom_range(7) == 0));
    end else if (kind < 90) begin
      build_encoded(n, 1'($urandom_range(1)), url);
      pos = $urandom_range(msg_q.size() - 1);
      case ($urandom_range(3))
        0: msg_q[pos] = 8'($urandom);
        1: if (msg_q.size() > 1) void'(msg_q.pop_back());
        2: msg_q.push_back(b64d_pkg::PadChar);
        default: msg_q.insert(pos, b64d_pkg::PadChar);
      endcase
    end else begin
      msg_q.delete();
      n = $urandom_range(6, 1);
      for (int unsigned i = 0; i < n; i++)
        msg_q.push_back(($urandom_range(7) == 0) ? b64d_pkg::PadChar : 8'($urandom));
    end
    send_message();
  endtask

  initial begin
    logic url;
    logic paused;
    board          = new();
    rst_ni         = 1'b0;
    push           = 1'b0;
    in_item        = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    chars_sent     = 0;
    msgs_sent      = 0;
    phase_items    = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset alphabet is standard
    send_text("TWFu");
    send_text("TQ==");
    send_text("TWE=");
    send_text("A");     // one past a quartet
    send_text("TQ=");   // padded, wrong length
    send_text("TQ=A");  // data after padding
    send_text("-_+/");  // URL characters rejected here
    msg_q.delete();
    msg_q.push_back(8'hff);
    msg_q.push_back(8'h00);
    send_message();
    drain();

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      url = ph[0] ^ ph[2];
      write_alphabet(url);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      // receiver holds off while the sender keeps pushing
      if (ph == 0) hold_left = HoldCycles;
      phase_items = 0;
      paused = 1'b0;
      while (phase_items < ItemsPerPhase) begin
        random_message(url);
        if (ph == 3 && !paused && phase_items > ItemsPerPhase / 2) begin
          push <= 1'b0;
          while (board.pending() != 0) @(posedge clk_i);
          paused = 1'b1;
        end
      end
      drain();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));
    $display("Sent %0d characters in %0d messages, checked %0d results,", chars_sent,
             msgs_sent, board.checked);
    $display("both alphabet settings, with and without idling on either side.");
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ base64_stream_decoder_core.f @@
src/b64d_pkg.sv
src/b64d_fifo.sv
src/b64d_front.sv
src/b64d_back.sv
src/base64_stream_decoder_core.sv
tb/sv/testbench.sv
